// ===== src/multitap_keypad_text_entry_defines.svh =====
// assertion macros for the multi-tap text entry block
`ifndef MULTITAP_KEYPAD_TEXT_ENTRY_DEFINES_SVH
`define MULTITAP_KEYPAD_TEXT_ENTRY_DEFINES_SVH

// same-cycle implication
`define MTE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mte assertion failed");

// next-cycle implication
`define MTE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mte assertion failed");

`endif

// ===== src/mte_pkg.sv =====
// package: types, codes and letter tables of the multi-tap text entry block
package mte_pkg;

  localparam int unsigned TEXT_DEPTH_DEF = 32;
  localparam int unsigned LEN_W          = 6;
  localparam int unsigned POS_W          = 6;
  localparam int unsigned TICK_W         = 16;
  localparam int unsigned TAP_W          = 3;
  localparam int unsigned KEY_W          = 4;
  localparam int unsigned CHAR_W         = 8;

  localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd1000;

  localparam logic            OP_TICK        = 1'b0;
  localparam logic            OP_KEY         = 1'b1;
  localparam logic [KEY_W-1:0] KEY_ONE        = 4'd1;
  localparam logic [KEY_W-1:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [KEY_W-1:0] KEY_BACK       = 4'd10;
  localparam logic [KEY_W-1:0] KEY_SEND       = 4'd11;
  localparam logic [KEY_W-1:0] NO_KEY         = 4'd15;

  typedef enum logic [2:0] {
    ACT_APPEND  = 3'd0,
    ACT_REPLACE = 3'd1,
    ACT_DELETE  = 3'd2,
    ACT_SENT    = 3'd3,
    ACT_EMPTY   = 3'd4,
    ACT_DROP    = 3'd5
  } action_e;

  typedef struct packed {
    logic item_load;
    logic exec;
    logic run_read;
    logic run_emit;
  } mte_cmd_t;

  typedef struct packed {
    logic needs_slot;
    logic run;
    logic slot_free;
    logic run_last;
  } mte_status_t;

  function automatic logic [TAP_W-1:0] letter_count(input logic [KEY_W-1:0] key);
    logic [TAP_W-1:0] n;
    case (key)
      4'd0:    n = 3'd2;
      4'd7:    n = 3'd5;
      4'd9:    n = 3'd5;
      4'd1:    n = 3'd1;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [CHAR_W-1:0] letter_of(input logic [KEY_W-1:0] key,
                                                 input logic [TAP_W-1:0] tap);
    logic [CHAR_W-1:0] c;
    c = 8'h00;
    case (key)
      4'd0: c = (tap == 3'd0) ? 8'h20 : "0";
      4'd2: case (tap) 3'd0: c = "A"; 3'd1: c = "B"; 3'd2: c = "C"; default: c = "2"; endcase
      4'd3: case (tap) 3'd0: c = "D"; 3'd1: c = "E"; 3'd2: c = "F"; default: c = "3"; endcase
      4'd4: case (tap) 3'd0: c = "G"; 3'd1: c = "H"; 3'd2: c = "I"; default: c = "4"; endcase
      4'd5: case (tap) 3'd0: c = "J"; 3'd1: c = "K"; 3'd2: c = "L"; default: c = "5"; endcase
      4'd6: case (tap) 3'd0: c = "M"; 3'd1: c = "N"; 3'd2: c = "O"; default: c = "6"; endcase
      4'd7: case (tap)
              3'd0: c = "P"; 3'd1: c = "Q"; 3'd2: c = "R"; 3'd3: c = "S";
              default: c = "7";
            endcase
      4'd8: case (tap) 3'd0: c = "T"; 3'd1: c = "U"; 3'd2: c = "V"; default: c = "8"; endcase
      4'd9: case (tap)
              3'd0: c = "W"; 3'd1: c = "X"; 3'd2: c = "Y"; 3'd3: c = "Z";
              default: c = "9";
            endcase
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/mte_if.sv =====
// valid/ready channels for key items and result items
interface mte_in_if import mte_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface mte_out_if import mte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [CHAR_W-1:0] char_code;
  logic [POS_W-1:0]  position;
  logic              last;

  modport source (output valid, output action, output char_code, output position,
                  output last, input ready);
  modport sink   (input valid, input action, input char_code, input position,
                  input last, output ready);
endinterface

// ===== src/multitap_keypad_text_entry.sv =====
// top level of the multi-tap keypad text entry block
// Each input item (timer tick or key press) is taken in S_IDLE and executed in
// S_EXEC, where a key that yields a result waits for a free output slot. A new
// item is accepted while an earlier result still sits in the output register.
// A send run reads each character in S_RUN_RD and emits it in S_RUN_OUT once
// the output slot is free, as the text store has one registered read port; no
// item is taken mid-run. The text store needs no clearing after reset.
module multitap_keypad_text_entry import mte_pkg::*; #(
  parameter int unsigned TEXT_DEPTH = TEXT_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TICK_W-1:0] cfg_wdata_i,
  mte_in_if.sink            item_i,
  mte_out_if.source         result_o
);

  mte_cmd_t    cmd;
  mte_status_t status;
  action_e     action;

  mte_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  mte_dp #(
    .TEXT_DEPTH (TEXT_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_op_i    (item_i.op),
    .item_key_i   (item_i.key),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (result_o.valid),
    .out_action_o (action),
    .out_char_o   (result_o.char_code),
    .out_pos_o    (result_o.position),
    .out_last_o   (result_o.last)
  );

  assign result_o.action = action;

endmodule

// ===== src/mte_ram.sv =====
// generic simple dual-port ram with registered read
module mte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mte_ctrl.sv =====
// control state machine: item intake, execution and send runs
module mte_ctrl import mte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  mte_status_t status_i,
  output mte_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RUN_RD,
    S_RUN_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!status_i.needs_slot || status_i.slot_free) begin
          cmd_o.exec = 1'b1;
          state_d    = status_i.run ? S_RUN_RD : S_IDLE;
        end
      end
      S_RUN_RD: begin
        cmd_o.run_read = 1'b1;
        state_d        = S_RUN_OUT;
      end
      S_RUN_OUT: begin
        if (status_i.slot_free) begin
          cmd_o.run_emit = 1'b1;
          state_d        = status_i.run_last ? S_IDLE : S_RUN_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign item_ready_o = (state_q == S_IDLE);

endmodule

// ===== src/mte_dp.sv =====
// datapath: tap state, text store, length, timeout register and result register
module mte_dp import mte_pkg::*; #(
  parameter int unsigned TEXT_DEPTH = TEXT_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TICK_W-1:0] cfg_wdata_i,
  input  logic              item_op_i,
  input  logic [KEY_W-1:0]  item_key_i,
  input  mte_cmd_t          cmd_i,
  output mte_status_t       status_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output action_e           out_action_o,
  output logic [CHAR_W-1:0] out_char_o,
  output logic [POS_W-1:0]  out_pos_o,
  output logic              out_last_o
);

  localparam int unsigned AW = $clog2(TEXT_DEPTH);
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(TEXT_DEPTH);

  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [KEY_W-1:0]  prev_q, prev_d;
  logic [TAP_W-1:0]  tap_q, tap_d;
  logic [TICK_W-1:0] ticks_q, ticks_d;
  logic [TICK_W-1:0] timeout_q;
  logic [LEN_W-1:0]  idx_q, idx_d;
  logic              valid_q, valid_d;
  action_e           action_q, action_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              last_q, last_d;
  logic              load;

  logic              is_key, is_back, is_send, is_digit, is_repeat, len_zero, full;
  logic [TAP_W-1:0]  tap_inc, tap_rep;
  logic [CHAR_W-1:0] ch;
  logic [LEN_W-1:0]  len_m1;
  logic [TICK_W-1:0] ticks_inc;
  logic              run_last;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [CHAR_W-1:0] rdata;

  assign is_key    = (op_q == OP_KEY);
  assign is_back   = is_key && (key_q == KEY_BACK);
  assign is_send   = is_key && (key_q == KEY_SEND);
  assign is_digit  = is_key && (key_q <= KEY_LAST_DIGIT) && (key_q != KEY_ONE);
  assign len_zero  = (len_q == '0);
  assign full      = (len_q >= DEPTH_LEN);
  assign is_repeat = is_digit && (prev_q == key_q) && !len_zero;
  assign tap_inc   = tap_q + TAP_W'(1);
  assign tap_rep   = (tap_inc == letter_count(key_q)) ? '0 : tap_inc;
  assign ch        = letter_of(key_q, is_repeat ? tap_rep : '0);
  assign len_m1    = len_q - LEN_W'(1);
  assign ticks_inc = (&ticks_q) ? ticks_q : ticks_q + TICK_W'(1);
  assign run_last  = (idx_q == len_m1);

  assign status_o.needs_slot = is_back || (is_send && len_zero) || is_digit;
  assign status_o.run        = is_send && !len_zero;
  assign status_o.slot_free  = !valid_q || out_ready_i;
  assign status_o.run_last   = run_last;

  always_comb begin
    len_d    = len_q;
    prev_d   = prev_q;
    tap_d    = tap_q;
    ticks_d  = ticks_q;
    idx_d    = idx_q;
    load     = 1'b0;
    action_d = action_q;
    char_d   = char_q;
    pos_d    = pos_q;
    last_d   = last_q;
    we       = 1'b0;
    waddr    = len_q[AW-1:0];
    if (cmd_i.exec) begin
      if (!is_key) begin
        ticks_d = ticks_inc;
        if (ticks_inc >= timeout_q) begin
          prev_d = NO_KEY;
          tap_d  = '0;
        end
      end else if (is_back) begin
        if (!len_zero) begin
          len_d = len_m1;
        end
        load     = 1'b1;
        action_d = ACT_DELETE;
        char_d   = '0;
        pos_d    = len_zero ? '0 : len_m1;
        last_d   = 1'b1;
        prev_d   = key_q;
        tap_d    = '0;
        ticks_d  = '0;
      end else if (is_send) begin
        prev_d  = key_q;
        tap_d   = '0;
        ticks_d = '0;
        idx_d   = '0;
        if (len_zero) begin
          load     = 1'b1;
          action_d = ACT_EMPTY;
          char_d   = '0;
          pos_d    = '0;
          last_d   = 1'b1;
        end
      end else if (is_digit) begin
        ticks_d = '0;
        load    = 1'b1;
        char_d  = ch;
        last_d  = 1'b1;
        if (is_repeat) begin
          tap_d    = tap_rep;
          we       = 1'b1;
          waddr    = len_m1[AW-1:0];
          action_d = ACT_REPLACE;
          pos_d    = len_m1;
        end else begin
          tap_d = '0;
          if (full) begin
            prev_d   = NO_KEY;
            action_d = ACT_DROP;
            pos_d    = DEPTH_LEN;
          end else begin
            we       = 1'b1;
            action_d = ACT_APPEND;
            pos_d    = len_q;
            len_d    = len_q + LEN_W'(1);
            prev_d   = key_q;
          end
        end
      end
    end
    if (cmd_i.run_emit) begin
      load     = 1'b1;
      action_d = ACT_SENT;
      char_d   = rdata;
      pos_d    = idx_q;
      last_d   = run_last;
      idx_d    = idx_q + LEN_W'(1);
      if (run_last) begin
        len_d = '0;
      end
    end
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      prev_q    <= NO_KEY;
      tap_q     <= '0;
      ticks_q   <= '0;
      timeout_q <= TIMEOUT_RST;
      idx_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      len_q   <= len_d;
      prev_q  <= prev_d;
      tap_q   <= tap_d;
      ticks_q <= ticks_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      op_q  <= item_op_i;
      key_q <= item_key_i;
    end
    action_q <= action_d;
    char_q   <= char_d;
    pos_q    <= pos_d;
    last_q   <= last_d;
  end

  mte_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (TEXT_DEPTH)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (ch),
    .re_i    (cmd_i.run_read),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign out_valid_o  = valid_q;
  assign out_action_o = action_q;
  assign out_char_o   = char_q;
  assign out_pos_o    = pos_q;
  assign out_last_o   = last_q;

endmodule

// ===== src/mte_checker.sv =====
// port-level checker for the multi-tap text entry block and its bind
`include "multitap_keypad_text_entry_defines.svh"

module mte_checker import mte_pkg::*; #(
  parameter int unsigned TEXT_DEPTH = TEXT_DEPTH_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [2:0]        out_action_i,
  input logic [CHAR_W-1:0] out_char_i,
  input logic [POS_W-1:0]  out_pos_i,
  input logic              out_last_i
);

  `MTE_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_action_i) && $stable(out_char_i) && $stable(out_pos_i) && $stable(out_last_i))
  `MTE_ASSERT_IMP(a_single_last, clk_i, rst_ni, out_valid_i && (out_action_i != ACT_SENT), out_last_i)
  `MTE_ASSERT_IMP(a_empty_send, clk_i, rst_ni, out_valid_i && (out_action_i == ACT_EMPTY), (out_char_i == '0) && (out_pos_i == '0))
  `MTE_ASSERT_IMP(a_pos_range, clk_i, rst_ni, out_valid_i, out_pos_i <= POS_W'(TEXT_DEPTH))

endmodule

bind multitap_keypad_text_entry mte_checker #(
  .TEXT_DEPTH (TEXT_DEPTH)
) u_mte_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_action_i (result_o.action),
  .out_char_i   (result_o.char_code),
  .out_pos_i    (result_o.position),
  .out_last_i   (result_o.last)
);

// ===== test/tb_multitap_keypad_text_entry.sv =====
// testbench for the multi-tap keypad text entry block: predicted results checked item by item
module tb_multitap_keypad_text_entry;
  import mte_pkg::*;

  localparam int unsigned TEXT_DEPTH    = TEXT_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  typedef struct {
    action_e          act;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic              last;
  } text_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [TICK_W-1:0] cfg_wdata_i;

  mte_in_if  key_if ();
  mte_out_if text_if ();

  multitap_keypad_text_entry #(
    .TEXT_DEPTH (TEXT_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (key_if),
    .result_o    (text_if)
  );

  // predicted block state
  logic [CHAR_W-1:0] text_buf [TEXT_DEPTH];
  int                text_len;
  logic [KEY_W-1:0]  tap_key;
  int                tap_pos;
  int                idle_ticks;
  int                tap_timeout;

  text_result_t text_results_q [$];
  int           mismatches;
  int           send_idle_pct;
  int           recv_idle_pct;
  int unsigned  cycle_count = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    text_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 40) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
    mismatches++;
  endtask

  function automatic string keypad_letters(input logic [KEY_W-1:0] key);
    string s;
    case (key)
      4'd0:    s = " 0";
      4'd2:    s = "ABC2";
      4'd3:    s = "DEF3";
      4'd4:    s = "GHI4";
      4'd5:    s = "JKL5";
      4'd6:    s = "MNO6";
      4'd7:    s = "PQRS7";
      4'd8:    s = "TUV8";
      4'd9:    s = "WXYZ9";
      default: s = "";
    endcase
    return s;
  endfunction

  function automatic void push_result(input action_e act, input logic [CHAR_W-1:0] ch,
                                      input int pos, input logic last);
    text_result_t r;
    r.act  = act;
    r.ch   = ch;
    r.pos  = pos[POS_W-1:0];
    r.last = last;
    text_results_q.push_back(r);
  endfunction

  task automatic apply_keypress(input logic op, input logic [KEY_W-1:0] key);
    string             letters;
    logic [CHAR_W-1:0] ch;
    int                i;
    letters = keypad_letters(key);
    if (op == OP_TICK) begin
      if (idle_ticks < 65535) idle_ticks++;
      if (idle_ticks >= tap_timeout) begin
        tap_key = NO_KEY;
        tap_pos = 0;
      end
    end else if (key == KEY_BACK) begin
      if (text_len > 0) text_len--;
      push_result(ACT_DELETE, 8'h00, text_len, 1'b1);
      tap_key    = key;
      tap_pos    = 0;
      idle_ticks = 0;
    end else if (key == KEY_SEND) begin
      tap_key    = key;
      tap_pos    = 0;
      idle_ticks = 0;
      if (text_len == 0) begin
        push_result(ACT_EMPTY, 8'h00, 0, 1'b1);
      end else begin
        for (i = 0; i < text_len; i++) begin
          push_result(ACT_SENT, text_buf[i], i, (i == text_len - 1));
        end
        text_len = 0;
      end
    end else if (key <= KEY_LAST_DIGIT && key != KEY_ONE) begin
      idle_ticks = 0;
      if (tap_key == key && text_len > 0) begin
        tap_pos = (tap_pos + 1) % letters.len();
        ch = letters[tap_pos];
        text_buf[text_len - 1] = ch;
        push_result(ACT_REPLACE, ch, text_len - 1, 1'b1);
      end else begin
        tap_pos = 0;
        ch = letters[0];
        if (text_len >= TEXT_DEPTH) begin
          tap_key = NO_KEY;
          push_result(ACT_DROP, ch, TEXT_DEPTH, 1'b1);
        end else begin
          text_buf[text_len] = ch;
          push_result(ACT_APPEND, ch, text_len, 1'b1);
          text_len++;
          tap_key = key;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    text_result_t want;
    if (rst_ni && text_if.valid && text_if.ready) begin
      if (text_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item action %0d char %h pos %0d last %b",
                                  text_if.action, text_if.char_code, text_if.position,
                                  text_if.last));
      end else begin
        want = text_results_q.pop_front();
        if (text_if.action !== want.act)
          report_mismatch($sformatf("action %0d, expected %0d", text_if.action, want.act));
        if (text_if.char_code !== want.ch)
          report_mismatch($sformatf("char_code %h, expected %h", text_if.char_code, want.ch));
        if (text_if.position !== want.pos)
          report_mismatch($sformatf("position %0d, expected %0d", text_if.position, want.pos));
        if (text_if.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", text_if.last, want.last));
      end
    end
  end

  task automatic send_item(input logic op, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      key_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    key_if.valid <= 1'b1;
    key_if.op    <= op;
    key_if.key   <= key;
    @(posedge clk_i);
    while (!key_if.ready) @(posedge clk_i);
    apply_keypress(op, key);
  endtask

  task automatic press_keys(input logic [KEY_W-1:0] key, input int presses);
    repeat (presses) send_item(OP_KEY, key);
  endtask

  task automatic send_ticks(input int ticks);
    repeat (ticks) send_item(OP_TICK, 4'($urandom_range(15)));
  endtask

  task automatic wait_idle();
    key_if.valid <= 1'b0;
    while (text_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_repeat_timeout(input int ticks);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks[TICK_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tap_timeout = ticks;
  endtask

  // reset timeout, letter cycling and wrap-around
  task automatic test_tap_cycling();
    press_keys(4'd2, 5);
    press_keys(4'd7, 6);
    press_keys(4'd0, 3);
    press_keys(4'd9, 1);
    send_item(OP_KEY, KEY_SEND);
  endtask

  task automatic test_empty_buffer();
    send_item(OP_KEY, KEY_BACK);
    send_item(OP_KEY, KEY_SEND);
    press_keys(4'd4, 1);
    send_item(OP_KEY, KEY_BACK);
    send_item(OP_KEY, KEY_BACK);
    press_keys(4'd4, 2);
    send_item(OP_KEY, KEY_SEND);
  endtask

  task automatic test_ignored_keys();
    int k;
    press_keys(4'd3, 1);
    send_item(OP_KEY, KEY_ONE);
    press_keys(4'd3, 1);
    for (k = 12; k < 16; k++) send_item(OP_KEY, 4'(k));
    press_keys(4'd3, 1);
    for (k = 4; k < 9; k++) press_keys(4'(k), 1);
    send_item(OP_TICK, NO_KEY);
    send_item(OP_KEY, KEY_BACK);
    send_item(OP_KEY, KEY_SEND);
  endtask

  task automatic test_full_buffer();
    int n;
    for (n = 0; n < TEXT_DEPTH + 1; n++) press_keys((n % 2 == 0) ? 4'd2 : 4'd3, 1);
    press_keys(4'd3, 1);
    press_keys(4'd8, 2);
    send_item(OP_KEY, KEY_BACK);
    press_keys(4'd8, 2);
    send_item(OP_KEY, KEY_SEND);
  endtask

  task automatic test_tap_timeout();
    set_repeat_timeout(3);
    press_keys(4'd5, 1);
    send_ticks(2);
    press_keys(4'd5, 1);
    send_ticks(3);
    press_keys(4'd5, 1);
    set_repeat_timeout(1);
    press_keys(4'd6, 1);
    send_ticks(1);
    press_keys(4'd6, 1);
    set_repeat_timeout(0);
    press_keys(4'd8, 2);
    send_ticks(1);
    press_keys(4'd8, 1);
    send_item(OP_KEY, KEY_SEND);
  endtask

  // timeout at its maximum, a few ticks never clear the tap state
  task automatic test_max_timeout();
    set_repeat_timeout(65535);
    press_keys(4'd4, 1);
    send_ticks(3);
    press_keys(4'd4, 1);
    send_ticks(4);
    press_keys(4'd4, 1);
    send_item(OP_KEY, KEY_SEND);
  endtask

  task automatic test_random_entry(input int n_items, input int back_pct, input int send_pct);
    int               done;
    int               pick;
    int               v;
    logic [KEY_W-1:0] digit;
    done  = 0;
    digit = 4'd2;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < back_pct) begin
        send_item(OP_KEY, KEY_BACK);
        done++;
      end else if (pick < back_pct + send_pct) begin
        send_item(OP_KEY, KEY_SEND);
        done++;
      end else if (pick < 75) begin
        // at least half the presses repeat the previous digit
        if ($urandom_range(1) == 0) begin
          v = $urandom_range(8);
          digit = (v == 0) ? 4'd0 : 4'(v + 1);
        end
        press_keys(digit, 1);
        done++;
      end else if (pick < 95) begin
        v = $urandom_range(1, tap_timeout + 2);
        send_ticks(v);
        done += v;
      end else begin
        v = $urandom_range(4);
        send_item(OP_KEY, (v == 0) ? KEY_ONE : KEY_SEND + 4'(v));
      end
    end
    send_item(OP_KEY, KEY_SEND);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    key_if.valid  = 1'b0;
    key_if.op     = OP_TICK;
    key_if.key    = '0;
    text_if.ready = 1'b0;
    mismatches    = 0;
    text_len      = 0;
    tap_key       = NO_KEY;
    tap_pos       = 0;
    idle_ticks    = 0;
    tap_timeout   = int'(TIMEOUT_RST);
    send_idle_pct = 32;
    recv_idle_pct = 84;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_tap_cycling();
    test_empty_buffer();
    test_ignored_keys();
    test_full_buffer();
    test_tap_timeout();
    set_repeat_timeout($urandom_range(2, 5));
    test_random_entry(55, 10, 6);

    wait_idle();
    send_idle_pct = 84;
    recv_idle_pct = 32;
    set_repeat_timeout($urandom_range(1, 6));
    test_random_entry(55, 3, 1);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_max_timeout();
    set_repeat_timeout($urandom_range(2, 8));
    test_random_entry(55, 8, 4);

    wait_idle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/mte_pkg.sv
src/mte_if.sv
src/mte_ram.sv
src/mte_ctrl.sv
src/mte_dp.sv
src/multitap_keypad_text_entry.sv
src/mte_checker.sv
test/tb_multitap_keypad_text_entry.sv
